### sv/fppa_pkg.sv
// Shared types, codes and field widths of the fit policy partition allocator.
`default_nettype none

package fppa_pkg;

   localparam int SLOTS_DEFAULT     = 16;
   localparam int SIZE_BITS_DEFAULT = 16;

   localparam int KIND_W     = 1;
   localparam int SLOT_W     = 4;
   localparam int AMOUNT_W   = 16;
   localparam int STATUS_W   = 2;
   localparam int POLICY_W   = 2;
   localparam int COUNT_W    = 5;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [KIND_W-1:0] KIND_LOAD    = 1'b0;
   localparam logic [KIND_W-1:0] KIND_REQUEST = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_LOADED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_GRANTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_WAIT    = 2'd2;

   localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_POLICY          = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PARTITION_COUNT = 2'd1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic active;
      logic found;
   } token_type;

endpackage

`default_nettype wire

### sv/fppa_if.sv
// Request, response and register write channels of the partition allocator.
`default_nettype none

interface fppa_req_if;
   logic                         valid;
   logic                         ready;
   logic [fppa_pkg::KIND_W-1:0]   kind;
   logic [fppa_pkg::SLOT_W-1:0]   slot;
   logic [fppa_pkg::AMOUNT_W-1:0] amount;

   modport source (output valid, kind, slot, amount, input ready);
   modport sink (input valid, kind, slot, amount, output ready);
endinterface

interface fppa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fppa_pkg::STATUS_W-1:0] status;
   logic [fppa_pkg::SLOT_W-1:0]   chosen_slot;
   logic [fppa_pkg::AMOUNT_W-1:0] hole_before;

   modport source (output valid, status, chosen_slot, hole_before, input ready);
   modport sink (input valid, status, chosen_slot, hole_before, output ready);
endinterface

interface fppa_csr_if;
   logic                           valid;
   logic                           ready;
   logic [fppa_pkg::CSR_ADDR_W-1:0] index;
   logic [fppa_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/fppa_cell.sv
// One partition slot: holds its free size and updates the passing search token.
`default_nettype none

module fppa_cell #(
   parameter int SIZE_BITS = fppa_pkg::SIZE_BITS_DEFAULT,
   parameter int IDX_W     = 4,
   parameter int INDEX     = 0
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire  [fppa_pkg::POLICY_W-1:0]     policy,
   input  wire  [SIZE_BITS-1:0]              amount,
   input  wire                               in_use,
   input  wire                               wr_en,
   input  wire  [IDX_W-1:0]                  wr_idx,
   input  wire  [SIZE_BITS-1:0]              wr_data,
   input  fppa_pkg::token_type               tok_in,
   input  wire  [IDX_W-1:0]                  pick_in,
   input  wire  [SIZE_BITS-1:0]              left_in,
   output fppa_pkg::token_type               tok_out,
   output logic [IDX_W-1:0]                  pick_out,
   output logic [SIZE_BITS-1:0]              left_out
);

   localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(INDEX);

   logic [SIZE_BITS-1:0] size_ff;
   fppa_pkg::token_type  tok_ff;
   fppa_pkg::token_type  tok_in_next;
   logic [IDX_W-1:0]     pick_ff;
   logic [IDX_W-1:0]     pick_in_next;
   logic [SIZE_BITS-1:0] left_ff;
   logic [SIZE_BITS-1:0] left_in_next;
   logic [SIZE_BITS-1:0] left;
   logic                 fits;
   logic                 better;
   logic                 take;

   assign fits = (size_ff >= amount);
   assign left = size_ff - amount;

   always_comb begin
      better = 1'b0;
      if (policy == fppa_pkg::POLICY_BEST) begin
         better = (left < left_in);
      end else if (policy == fppa_pkg::POLICY_WORST) begin
         better = (left > left_in);
      end
      take = tok_in.active && in_use && fits && (!tok_in.found || better);

      tok_in_next.active = tok_in.active;
      tok_in_next.found  = tok_in.found || take;
      pick_in_next       = take ? MY_INDEX : pick_in;
      left_in_next       = take ? left : left_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      pick_ff <= pick_in_next;
      left_ff <= left_in_next;
      if (wr_en && (wr_idx == MY_INDEX)) begin
         size_ff <= wr_data;
      end
   end

   assign tok_out  = tok_ff;
   assign pick_out = pick_ff;
   assign left_out = left_ff;

endmodule

`default_nettype wire

### sv/fit_policy_partition_allocator_unit.sv
// Top level of the fit policy partition allocator: control, registers and slot chain.
`default_nettype none

// A load request writes one slot's free size when it is accepted. The block then
// moves to its done state, and the response is registered out from there once
// the output register is free. An allocation request sends a search token down
// a chain of SLOTS cells, each of which registers it. Each cell in use compares
// its size against the amount under the first, best or worst fit rule. It hands
// the running choice to its neighbor. The winner is written back after the last
// cell. The response sits in an output register, and the next request is taken
// while it waits. Slot sizes are undefined until loaded. The user must write
// registers only while the block is idle; the block itself does not enforce it.
module fit_policy_partition_allocator_unit #(
   parameter int SLOTS     = fppa_pkg::SLOTS_DEFAULT,
   parameter int SIZE_BITS = fppa_pkg::SIZE_BITS_DEFAULT
) (
   input wire          clock,
   input wire          reset,
   fppa_req_if.sink    req,
   fppa_rsp_if.source  rsp,
   fppa_csr_if.sink    csr
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CMP_W = (IDX_W + 1 > fppa_pkg::COUNT_W) ? IDX_W + 1 : fppa_pkg::COUNT_W;

   fppa_pkg::state_type state_ff;
   fppa_pkg::state_type state_in;

   logic [fppa_pkg::POLICY_W-1:0] policy_ff;
   logic [fppa_pkg::COUNT_W-1:0]  count_ff;

   logic [SIZE_BITS-1:0]          amount_ff;
   logic [SIZE_BITS-1:0]          amount_in;
   logic [SIZE_BITS-1:0]          req_size;

   logic [fppa_pkg::STATUS_W-1:0] hold_status_ff;
   logic [fppa_pkg::STATUS_W-1:0] hold_status_in;
   logic [fppa_pkg::SLOT_W-1:0]   hold_slot_ff;
   logic [fppa_pkg::SLOT_W-1:0]   hold_slot_in;
   logic [fppa_pkg::AMOUNT_W-1:0] hold_hole_ff;
   logic [fppa_pkg::AMOUNT_W-1:0] hold_hole_in;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [fppa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [fppa_pkg::STATUS_W-1:0] rsp_status_in;
   logic [fppa_pkg::SLOT_W-1:0]   rsp_slot_ff;
   logic [fppa_pkg::SLOT_W-1:0]   rsp_slot_in;
   logic [fppa_pkg::AMOUNT_W-1:0] rsp_hole_ff;
   logic [fppa_pkg::AMOUNT_W-1:0] rsp_hole_in;

   logic                          req_accept;
   logic                          rsp_free;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_idx;
   logic [SIZE_BITS-1:0]          wr_data;
   logic [SIZE_BITS-1:0]          grant_size;

   fppa_pkg::token_type           tok   [SLOTS+1];
   logic [IDX_W-1:0]              pick  [SLOTS+1];
   logic [SIZE_BITS-1:0]          left  [SLOTS+1];
   logic [SLOTS-1:0]              in_use;

   // Register port
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= fppa_pkg::POLICY_FIRST;
         count_ff  <= fppa_pkg::COUNT_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            fppa_pkg::CSR_POLICY: begin
               policy_ff <= csr.data[fppa_pkg::POLICY_W-1:0];
            end
            fppa_pkg::CSR_PARTITION_COUNT: begin
               count_ff <= csr.data[fppa_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Slot chain
   assign tok[0].active = req_accept && (req.kind == fppa_pkg::KIND_REQUEST);
   assign tok[0].found  = 1'b0;
   assign pick[0]       = '0;
   assign left[0]       = '0;

   for (genvar j = 0; j < SLOTS; j++) begin : g_cell
      assign in_use[j] = (CMP_W'(j) < CMP_W'(count_ff));

      fppa_cell #(
         .SIZE_BITS (SIZE_BITS),
         .IDX_W     (IDX_W),
         .INDEX     (j)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .policy   (policy_ff),
         .amount   ((j == 0) ? req_size : amount_ff),
         .in_use   (in_use[j]),
         .wr_en    (wr_en),
         .wr_idx   (wr_idx),
         .wr_data  (wr_data),
         .tok_in   (tok[j]),
         .pick_in  (pick[j]),
         .left_in  (left[j]),
         .tok_out  (tok[j+1]),
         .pick_out (pick[j+1]),
         .left_out (left[j+1])
      );
   end

   // Control
   assign req.ready  = (state_ff == fppa_pkg::ST_IDLE);
   assign req_accept = req.valid && req.ready;
   assign req_size   = SIZE_BITS'(req.amount);
   assign rsp_free   = !rsp_valid_ff || rsp.ready;
   assign grant_size = left[SLOTS] + amount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fppa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      amount_ff      <= amount_in;
      hold_status_ff <= hold_status_in;
      hold_slot_ff   <= hold_slot_in;
      hold_hole_ff   <= hold_hole_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_hole_ff    <= rsp_hole_in;
   end

   always_comb begin
      state_in       = state_ff;
      amount_in      = amount_ff;
      hold_status_in = hold_status_ff;
      hold_slot_in   = hold_slot_ff;
      hold_hole_in   = hold_hole_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_hole_in    = rsp_hole_ff;
      wr_en          = 1'b0;
      wr_idx         = IDX_W'(req.slot);
      wr_data        = req_size;

      unique case (state_ff)
         fppa_pkg::ST_IDLE: begin
            if (req_accept) begin
               amount_in = req_size;
               if (req.kind == fppa_pkg::KIND_LOAD) begin
                  wr_en          = (int'(req.slot) < SLOTS);
                  hold_status_in = fppa_pkg::STATUS_LOADED;
                  hold_slot_in   = req.slot;
                  hold_hole_in   = fppa_pkg::AMOUNT_W'(req_size);
                  state_in       = fppa_pkg::ST_DONE;
               end else begin
                  state_in = fppa_pkg::ST_SCAN;
               end
            end
         end
         fppa_pkg::ST_SCAN: begin
            if (tok[SLOTS].active) begin
               state_in = fppa_pkg::ST_DONE;
               if (tok[SLOTS].found) begin
                  wr_en          = 1'b1;
                  wr_idx         = pick[SLOTS];
                  wr_data        = left[SLOTS];
                  hold_status_in = fppa_pkg::STATUS_GRANTED;
                  hold_slot_in   = fppa_pkg::SLOT_W'(pick[SLOTS]);
                  hold_hole_in   = fppa_pkg::AMOUNT_W'(grant_size);
               end else begin
                  hold_status_in = fppa_pkg::STATUS_WAIT;
                  hold_slot_in   = '0;
                  hold_hole_in   = '0;
               end
            end
         end
         fppa_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = hold_status_ff;
               rsp_slot_in   = hold_slot_ff;
               rsp_hole_in   = hold_hole_ff;
               state_in      = fppa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fppa_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.chosen_slot = rsp_slot_ff;
   assign rsp.hole_before = rsp_hole_ff;

endmodule

`default_nettype wire

### tb/fit_policy_partition_allocator_unit_tb.sv
// Self-checking testbench for the fit policy partition allocator top level.
`timescale 1ns / 1ps

module fit_policy_partition_allocator_unit_tb;

   localparam int SLOT_COUNT   = fppa_pkg::SLOTS_DEFAULT;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 2 * SLOT_COUNT + 8;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 140;
   localparam int PRINT_LIMIT  = 50;

   localparam logic [fppa_pkg::POLICY_W-1:0]   POLICY_UNUSED = 2'd3;
   localparam logic [fppa_pkg::CSR_ADDR_W-1:0] CSR_SPARE_LO  = 2'd2;
   localparam logic [fppa_pkg::CSR_ADDR_W-1:0] CSR_SPARE_HI  = 2'd3;

   typedef struct packed {
      logic [fppa_pkg::STATUS_W-1:0] status;
      logic [fppa_pkg::SLOT_W-1:0]   chosen_slot;
      logic [fppa_pkg::AMOUNT_W-1:0] hole_before;
   } alloc_result_type;

   logic clock;
   logic reset;

   fppa_req_if req_ch();
   fppa_rsp_if rsp_ch();
   fppa_csr_if csr_ch();

   fit_policy_partition_allocator_unit uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr(csr_ch)
   );

   logic [fppa_pkg::AMOUNT_W-1:0] free_size [SLOT_COUNT];
   logic [fppa_pkg::POLICY_W-1:0] fit_policy;
   logic [fppa_pkg::COUNT_W-1:0]  slots_in_use;
   alloc_result_type              expected_results [$];

   int error_count   = 0;
   int cycle_count   = 0;
   int load_total    = 0;
   int grant_total   = 0;
   int wait_total    = 0;
   int setting_total = 0;
   bit steady_sender   = 1'b0;
   bit steady_receiver = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, expected_results.size());
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic alloc_result_type predict_allocation(
         input logic [fppa_pkg::KIND_W-1:0]   kind,
         input logic [fppa_pkg::SLOT_W-1:0]   slot,
         input logic [fppa_pkg::AMOUNT_W-1:0] amount);
      alloc_result_type              res;
      int                            limit;
      int                            pick;
      bit                            found;
      logic [fppa_pkg::AMOUNT_W-1:0] left;
      logic [fppa_pkg::AMOUNT_W-1:0] pick_left;
      res       = '0;
      pick      = 0;
      found     = 1'b0;
      pick_left = '0;
      if (kind == fppa_pkg::KIND_LOAD) begin
         free_size[slot]  = amount;
         res.status       = fppa_pkg::STATUS_LOADED;
         res.chosen_slot  = slot;
         res.hole_before  = amount;
         return res;
      end
      limit = (slots_in_use > SLOT_COUNT) ? SLOT_COUNT : int'(slots_in_use);
      for (int j = 0; j < limit; j++) begin
         if (free_size[j] >= amount) begin
            left = free_size[j] - amount;
            if (!found || (fit_policy == fppa_pkg::POLICY_BEST && left < pick_left)
                || (fit_policy == fppa_pkg::POLICY_WORST && left > pick_left)) begin
               found     = 1'b1;
               pick      = j;
               pick_left = left;
            end
         end
      end
      if (!found) begin
         res.status = fppa_pkg::STATUS_WAIT;
         return res;
      end
      res.status      = fppa_pkg::STATUS_GRANTED;
      res.chosen_slot = pick[fppa_pkg::SLOT_W-1:0];
      res.hole_before = free_size[pick];
      free_size[pick] = pick_left;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      end
   endtask

   task automatic send_request(input logic [fppa_pkg::KIND_W-1:0]   kind,
                               input logic [fppa_pkg::SLOT_W-1:0]   slot,
                               input logic [fppa_pkg::AMOUNT_W-1:0] amount);
      int               gap;
      alloc_result_type res;
      gap = steady_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.kind   <= kind;
      req_ch.slot   <= slot;
      req_ch.amount <= amount;
      do @(posedge clock); while (!req_ch.ready);
      res = predict_allocation(kind, slot, amount);
      expected_results.push_back(res);
      case (res.status)
         fppa_pkg::STATUS_LOADED: load_total++;
         fppa_pkg::STATUS_GRANTED: grant_total++;
         default: wait_total++;
      endcase
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [fppa_pkg::CSR_ADDR_W-1:0] index,
                                 input logic [fppa_pkg::CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (index == fppa_pkg::CSR_POLICY) begin
         fit_policy = data[fppa_pkg::POLICY_W-1:0];
      end else if (index == fppa_pkg::CSR_PARTITION_COUNT) begin
         slots_in_use = data[fppa_pkg::COUNT_W-1:0];
      end
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [fppa_pkg::POLICY_W-1:0] policy,
                                input logic [fppa_pkg::COUNT_W-1:0]  count);
      logic [fppa_pkg::CSR_DATA_W-1:0] policy_word;
      logic [fppa_pkg::CSR_DATA_W-1:0] count_word;
      policy_word = fppa_pkg::CSR_DATA_W'($urandom);
      count_word  = fppa_pkg::CSR_DATA_W'($urandom);
      policy_word[fppa_pkg::POLICY_W-1:0] = policy;
      count_word[fppa_pkg::COUNT_W-1:0]   = count;
      wait_idle();
      write_register(fppa_pkg::CSR_POLICY, policy_word);
      write_register(fppa_pkg::CSR_PARTITION_COUNT, count_word);
      setting_total++;
   endtask

   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("response with none expected: status %0d slot %0d hole %0d",
                                      rsp_ch.status, rsp_ch.chosen_slot, rsp_ch.hole_before));
         end else begin
            want = expected_results.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_ch.status, want.status));
            if (rsp_ch.chosen_slot !== want.chosen_slot)
               report_mismatch($sformatf("chosen_slot %0d, expected %0d",
                                         rsp_ch.chosen_slot, want.chosen_slot));
            if (rsp_ch.hole_before !== want.hole_before)
               report_mismatch($sformatf("hole_before %0d, expected %0d",
                                         rsp_ch.hole_before, want.hole_before));
         end
      end
   end

   initial begin
      int run;
      int stall;
      forever begin
         rsp_ch.ready <= 1'b1;
         run = $urandom_range(1, 12);
         repeat (run) @(posedge clock);
         stall = steady_receiver ? 0 : pick_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   task automatic test_load_slots();
      logic [fppa_pkg::AMOUNT_W-1:0] size;
      for (int j = 0; j < SLOT_COUNT; j++) begin
         case (j)
            0: size = 16'd100;
            1, 3: size = 16'd50;
            2: size = 16'hFFFF;
            4: size = 16'd0;
            15: size = 16'd60000;
            default: size = 16'd200;
         endcase
         send_request(fppa_pkg::KIND_LOAD, j[fppa_pkg::SLOT_W-1:0], size);
      end
   endtask

   task automatic test_first_fit();
      send_request(fppa_pkg::KIND_REQUEST, 4'hF, 16'd0);
      send_request(fppa_pkg::KIND_REQUEST, 4'h0, 16'hFFFF);
      send_request(fppa_pkg::KIND_REQUEST, 4'h5, 16'hFFFF);
   endtask

   task automatic test_fit_policies();
      apply_setting(fppa_pkg::POLICY_BEST, 5'd16);
      send_request(fppa_pkg::KIND_REQUEST, 4'h0, 16'd50);
      apply_setting(fppa_pkg::POLICY_WORST, 5'd15);
      send_request(fppa_pkg::KIND_REQUEST, 4'hA, 16'd10);
      apply_setting(POLICY_UNUSED, 5'd16);
      send_request(fppa_pkg::KIND_REQUEST, 4'h3, 16'd60);
   endtask

   task automatic test_count_limits();
      wait_idle();
      write_register(CSR_SPARE_LO, fppa_pkg::CSR_DATA_W'($urandom));
      write_register(CSR_SPARE_HI, fppa_pkg::CSR_DATA_W'($urandom));
      apply_setting(fppa_pkg::POLICY_FIRST, 5'd0);
      send_request(fppa_pkg::KIND_REQUEST, 4'h0, 16'd0);
      apply_setting(fppa_pkg::POLICY_BEST, 5'd31);
      send_request(fppa_pkg::KIND_REQUEST, 4'h7, 16'd60000);
      apply_setting(fppa_pkg::POLICY_FIRST, 5'd1);
      send_request(fppa_pkg::KIND_REQUEST, 4'hC, 16'd41);
   endtask

   task automatic test_random_traffic();
      logic [fppa_pkg::POLICY_W-1:0] policy;
      logic [fppa_pkg::COUNT_W-1:0]  count;
      logic [fppa_pkg::AMOUNT_W-1:0] amount;
      int                            roll;
      for (int p = 0; p < PHASES; p++) begin
         policy = (p < 8) ? p[fppa_pkg::POLICY_W-1:0]
                          : fppa_pkg::POLICY_W'($urandom_range(0, 3));
         case (p % 5)
            0: count = 5'd16;
            1: count = 5'd1;
            2: count = fppa_pkg::COUNT_W'($urandom_range(2, 15));
            3: count = 5'd31;
            default: count = fppa_pkg::COUNT_W'($urandom_range(17, 30));
         endcase
         if (p == 5) count = 5'd0;
         if (p == 7) begin
            wait_idle();
            write_register($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                           fppa_pkg::CSR_DATA_W'($urandom));
         end
         apply_setting(policy, count);
         steady_sender   = (p % 4 == 3);
         steady_receiver = (p % 5 == 2);
         for (int j = 0; j < SLOT_COUNT; j++) begin
            send_request(fppa_pkg::KIND_LOAD, j[fppa_pkg::SLOT_W-1:0],
                         fppa_pkg::AMOUNT_W'($urandom));
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
               amount = ($urandom_range(0, 1) != 0) ? fppa_pkg::AMOUNT_W'($urandom)
                                                    : fppa_pkg::AMOUNT_W'($urandom_range(0, 8000));
               send_request(fppa_pkg::KIND_LOAD, fppa_pkg::SLOT_W'($urandom), amount);
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 10) amount = '0;
               else if (roll < 20) amount = fppa_pkg::AMOUNT_W'($urandom);
               else amount = fppa_pkg::AMOUNT_W'($urandom_range(0, 2000));
               send_request(fppa_pkg::KIND_REQUEST, fppa_pkg::SLOT_W'($urandom), amount);
            end
         end
         steady_sender   = 1'b0;
         steady_receiver = 1'b0;
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.kind   <= fppa_pkg::KIND_LOAD;
      req_ch.slot   <= '0;
      req_ch.amount <= '0;
      csr_ch.valid  <= 1'b0;
      csr_ch.index  <= fppa_pkg::CSR_POLICY;
      csr_ch.data   <= '0;
      for (int j = 0; j < SLOT_COUNT; j++) free_size[j] = '0;
      fit_policy   = fppa_pkg::POLICY_FIRST;
      slots_in_use = fppa_pkg::COUNT_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_load_slots();
      test_first_fit();
      test_fit_policies();
      test_count_limits();
      test_random_traffic();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d loads, %0d grants and %0d waits across %0d register settings",
               load_total, grant_total, wait_total, setting_total);
      $display("All four policy codes, counts 0/1/16/31 and saturation ran in %0d cycles",
               cycle_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
